// ===== src/two_level_cache_lru_write_through_top_assert.svh =====
// Assertion macros of the cache top level.
`ifndef TWO_LEVEL_CACHE_LRU_WRITE_THROUGH_TOP_ASSERT_SVH
`define TWO_LEVEL_CACHE_LRU_WRITE_THROUGH_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge, masked while reset is asserted.
`define CLTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, including during reset.
`define CLTW_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLTW_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLTW_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== src/cltw_pkg.sv =====
// Types, constants and helper functions of the two-level cache.
package cltw_pkg;

    localparam int ADDR_W     = 12;
    localparam int WORD_W     = 32;
    localparam int LAT_W      = 10;
    localparam int AGE_W      = 8;
    localparam int AGE_MAX    = 255;
    localparam int LINE_WORDS = 4;
    localparam int OFF_W      = 2;
    localparam int CORE_W     = 2;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_CORES     = 4;
    localparam int DEF_NEAR_SETS = 16;
    localparam int DEF_NEAR_WAYS = 2;
    localparam int DEF_FAR_SETS  = 64;
    localparam int DEF_FAR_WAYS  = 4;
    localparam int DEF_MEM_BYTES = 4096;

    localparam logic [LAT_W-1:0] RST_L1_LAT  = 10'd1;
    localparam logic [LAT_W-1:0] RST_L2_LAT  = 10'd10;
    localparam logic [LAT_W-1:0] RST_MEM_LAT = 10'd100;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        SRV_L1  = 2'd0,
        SRV_L2  = 2'd1,
        SRV_MEM = 2'd2
    } served_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_L1_LAT  = 2'd0,
        REG_L2_LAT  = 2'd1,
        REG_MEM_LAT = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAGRD,
        ST_TAGCHK,
        ST_ACT,
        ST_COPY,
        ST_WAITRD,
        ST_RESP
    } state_t;

    // Address width for a given depth, never below one bit.
    function automatic int clog2_min1(input int n);
        int r;
        r = $clog2(n);
        return (r < 1) ? 1 : r;
    endfunction

endpackage

// ===== src/two_level_cache_lru_write_through_top.sv =====
// Top level of the two-level write-through cache with age-based LRU.
//
// One word access per transaction; the block takes one access at a time under a
// small sequencer. After reset a clearing pass zeroes all MEM_BYTES/4 words of
// main memory (1024 by default) before the first access is taken. An access then
// reads its rows from the tag/age row memories (TAGRD, TAGCHK) and acts (ACT): a
// write goes on to RESP, a first level read hit reads its word (WAITRD), and a
// second level hit or memory fill copies the line in (COPY), one line word per
// cycle through the single read port of the source memory. RESP loads the output
// register. Bad addresses go straight to RESP. Results wait in an output register.
`include "two_level_cache_lru_write_through_top_assert.svh"
module two_level_cache_lru_write_through_top #(
    parameter int CORES     = cltw_pkg::DEF_CORES,
    parameter int NEAR_SETS = cltw_pkg::DEF_NEAR_SETS,
    parameter int NEAR_WAYS = cltw_pkg::DEF_NEAR_WAYS,
    parameter int FAR_SETS  = cltw_pkg::DEF_FAR_SETS,
    parameter int FAR_WAYS  = cltw_pkg::DEF_FAR_WAYS,
    parameter int MEM_BYTES = cltw_pkg::DEF_MEM_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op, core, byte_address, write_word
    input  logic [cltw_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_word, served_by, latency, status
    output logic [cltw_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cltw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cltw_pkg::LAT_W-1:0]     cfg_data
);

    localparam int ADDR_W    = cltw_pkg::ADDR_W;
    localparam int WORD_W    = cltw_pkg::WORD_W;
    localparam int AGE_W     = cltw_pkg::AGE_W;
    localparam int LINE_W    = ADDR_W - 4;
    localparam int WIDX_W    = ADDR_W - 2;
    localparam int NSET_B    = $clog2(NEAR_SETS);
    localparam int NTAG_W    = (LINE_W - NSET_B > 0) ? LINE_W - NSET_B : 1;
    localparam int NROWS     = CORES * NEAR_SETS;
    localparam int NROW_W    = cltw_pkg::clog2_min1(NROWS);
    localparam int NWAY_W    = cltw_pkg::clog2_min1(NEAR_WAYS);
    localparam int NROW_BITS = NEAR_WAYS * (NTAG_W + AGE_W);
    localparam int NDEPTH    = NROWS * NEAR_WAYS * cltw_pkg::LINE_WORDS;
    localparam int NDA_W     = cltw_pkg::clog2_min1(NDEPTH);
    localparam int FSET_B    = $clog2(FAR_SETS);
    localparam int FSET_W    = cltw_pkg::clog2_min1(FAR_SETS);
    localparam int FTAG_W    = (LINE_W - FSET_B > 0) ? LINE_W - FSET_B : 1;
    localparam int FWAY_W    = cltw_pkg::clog2_min1(FAR_WAYS);
    localparam int FROW_BITS = FAR_WAYS * (FTAG_W + AGE_W);
    localparam int FDEPTH    = FAR_SETS * FAR_WAYS * cltw_pkg::LINE_WORDS;
    localparam int FDA_W     = cltw_pkg::clog2_min1(FDEPTH);
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int MA_W      = cltw_pkg::clog2_min1(MEM_WORDS);

    cltw_pkg::state_t state_reg, state_next;

    logic                      op_reg, op_next;
    logic [1:0]                core_reg, core_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [WORD_W-1:0]         wdata_reg, wdata_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic [MA_W-1:0]           clr_reg, clr_next;
    logic [cltw_pkg::LAT_W-1:0] lat1_reg, lat2_reg, lat3_reg;

    logic                      nhit_reg, nhit_next, fhit_reg, fhit_next;
    logic [NWAY_W-1:0]         nway_reg, nway_next;
    logic [FWAY_W-1:0]         fway_reg, fway_next;
    logic [NROW_BITS-1:0]      nnew_reg, nnew_next;
    logic [FROW_BITS-1:0]      fnew_reg, fnew_next;

    logic [WORD_W-1:0]         res_word_reg, res_word_next;
    cltw_pkg::served_t         res_srv_reg, res_srv_next;
    logic [cltw_pkg::LAT_W-1:0] res_lat_reg, res_lat_next;
    logic                      res_err_reg, res_err_next;

    logic                      m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]         m_word_reg, m_word_next;
    cltw_pkg::served_t         m_srv_reg, m_srv_next;
    logic [cltw_pkg::LAT_W-1:0] m_lat_reg, m_lat_next;
    logic                      m_err_reg, m_err_next;

    logic [NEAR_WAYS-1:0]      nvalid_reg [NROWS];
    logic [FAR_WAYS-1:0]       fvalid_reg [FAR_SETS];
    logic                      nv_set, fv_set;

    // Address decode of the held access.
    logic [LINE_W-1:0]         line;
    logic [cltw_pkg::OFF_W-1:0] off;
    logic [NROW_W-1:0]         nrow;
    logic [NTAG_W-1:0]         ntag;
    logic [FSET_W-1:0]         fset;
    logic [FTAG_W-1:0]         ftag;
    logic [WIDX_W-1:0]         first_word;
    logic [1:0]                cidx;
    logic                      src_in_mem;
    logic [WORD_W-1:0]         src_word;
    logic [ADDR_W-1:0]         in_addr;
    logic                      in_err;

    assign line       = addr_reg[ADDR_W-1:4];
    assign off        = addr_reg[3:2];
    assign nrow       = NROW_W'((int'(core_reg) % CORES) * NEAR_SETS + int'(line) % NEAR_SETS);
    assign ntag       = NTAG_W'(int'(line) / NEAR_SETS);
    assign fset       = FSET_W'(int'(line) % FAR_SETS);
    assign ftag       = FTAG_W'(int'(line) / FAR_SETS);
    assign first_word = {line, 2'b00};
    assign in_addr    = s_tdata[14:3];
    assign in_err     = (in_addr[1:0] != 2'b00) || (int'(in_addr) + 3 >= MEM_BYTES);

    // Memory ports.
    logic                 m_we;
    logic [MA_W-1:0]      m_waddr, m_raddr;
    logic [WORD_W-1:0]    m_wdata, m_rdata;
    logic                 nd_we;
    logic [NDA_W-1:0]     nd_waddr, nd_raddr;
    logic [WORD_W-1:0]    nd_wdata, nd_rdata;
    logic                 fd_we;
    logic [FDA_W-1:0]     fd_waddr, fd_raddr;
    logic [WORD_W-1:0]    fd_wdata, fd_rdata;
    logic                 nt_we, ft_we;
    logic [NROW_BITS-1:0] nt_rdata;
    logic [FROW_BITS-1:0] ft_rdata;

    // Word address of a line word in the first and second level data stores.
    logic [NDA_W-1:0] nd_base;
    logic [FDA_W-1:0] fd_base;
    assign nd_base = NDA_W'((int'(nrow) * NEAR_WAYS + int'(nway_reg)) * cltw_pkg::LINE_WORDS);
    assign fd_base = FDA_W'((int'(fset) * FAR_WAYS + int'(fway_reg)) * cltw_pkg::LINE_WORDS);

    // Line copy reads one word ahead of the word being written.
    assign cidx       = (state_reg == cltw_pkg::ST_COPY) ? cnt_reg + 2'd1 : 2'd0;
    assign m_raddr    = MA_W'(int'(first_word) + int'(cidx));
    assign fd_raddr   = fd_base + FDA_W'(cidx);
    assign src_in_mem = (int'(first_word) + int'(cnt_reg)) < MEM_WORDS;
    assign src_word   = fhit_reg ? fd_rdata : (src_in_mem ? m_rdata : '0);

    cltw_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_main (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );
    cltw_ram #(.WIDTH(WORD_W), .DEPTH(NDEPTH)) u_near_data (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata)
    );
    cltw_ram #(.WIDTH(WORD_W), .DEPTH(FDEPTH)) u_far_data (
        .clk(clk), .we(fd_we), .waddr(fd_waddr), .wdata(fd_wdata),
        .raddr(fd_raddr), .rdata(fd_rdata)
    );
    cltw_ram #(.WIDTH(NROW_BITS), .DEPTH(NROWS)) u_near_tag (
        .clk(clk), .we(nt_we), .waddr(nrow), .wdata(nnew_reg),
        .raddr(nrow), .rdata(nt_rdata)
    );
    cltw_ram #(.WIDTH(FROW_BITS), .DEPTH(FAR_SETS)) u_far_tag (
        .clk(clk), .we(ft_we), .waddr(fset), .wdata(fnew_reg),
        .raddr(fset), .rdata(ft_rdata)
    );

    // First level set: hit search, victim choice and aged row.
    always_comb
    begin
        logic [NEAR_WAYS-1:0] nv;
        logic [NTAG_W-1:0]    t;
        logic [AGE_W-1:0]     a;
        logic                 found_inv;
        int                   best;
        logic [NWAY_W-1:0]    vic, hway, used;
        nv        = nvalid_reg[nrow];
        nhit_next = 1'b0;
        hway      = '0;
        vic       = '0;
        found_inv = 1'b0;
        best      = -1;
        for (int w = 0; w < NEAR_WAYS; w++)
        begin
            t = nt_rdata[w*NTAG_W +: NTAG_W];
            a = nv[w] ? nt_rdata[NEAR_WAYS*NTAG_W + w*AGE_W +: AGE_W] : '0;
            if (!nhit_next && nv[w] && t == ntag)
            begin
                nhit_next = 1'b1;
                hway      = NWAY_W'(w);
            end
            if (!found_inv)
            begin
                if (!nv[w])
                begin
                    found_inv = 1'b1;
                    vic       = NWAY_W'(w);
                end
                else if (int'(a) > best)
                begin
                    best = int'(a);
                    vic  = NWAY_W'(w);
                end
            end
        end
        used      = nhit_next ? hway : vic;
        nway_next = used;
        for (int w = 0; w < NEAR_WAYS; w++)
        begin
            t = nt_rdata[w*NTAG_W +: NTAG_W];
            a = nv[w] ? nt_rdata[NEAR_WAYS*NTAG_W + w*AGE_W +: AGE_W] : '0;
            if (NWAY_W'(w) == used)
            begin
                nnew_next[w*NTAG_W +: NTAG_W]                    = ntag;
                nnew_next[NEAR_WAYS*NTAG_W + w*AGE_W +: AGE_W]   = '0;
            end
            else
            begin
                nnew_next[w*NTAG_W +: NTAG_W] = t;
                nnew_next[NEAR_WAYS*NTAG_W + w*AGE_W +: AGE_W] =
                    (nv[w] && int'(a) < cltw_pkg::AGE_MAX) ? a + AGE_W'(1) : a;
            end
        end
    end

    // Second level set: hit search, victim choice and aged row.
    always_comb
    begin
        logic [FAR_WAYS-1:0] fv;
        logic [FTAG_W-1:0]   t;
        logic [AGE_W-1:0]    a;
        logic                found_inv;
        int                  best;
        logic [FWAY_W-1:0]   vic, hway, used;
        fv        = fvalid_reg[fset];
        fhit_next = 1'b0;
        hway      = '0;
        vic       = '0;
        found_inv = 1'b0;
        best      = -1;
        for (int w = 0; w < FAR_WAYS; w++)
        begin
            t = ft_rdata[w*FTAG_W +: FTAG_W];
            a = fv[w] ? ft_rdata[FAR_WAYS*FTAG_W + w*AGE_W +: AGE_W] : '0;
            if (!fhit_next && fv[w] && t == ftag)
            begin
                fhit_next = 1'b1;
                hway      = FWAY_W'(w);
            end
            if (!found_inv)
            begin
                if (!fv[w])
                begin
                    found_inv = 1'b1;
                    vic       = FWAY_W'(w);
                end
                else if (int'(a) > best)
                begin
                    best = int'(a);
                    vic  = FWAY_W'(w);
                end
            end
        end
        used      = fhit_next ? hway : vic;
        fway_next = used;
        for (int w = 0; w < FAR_WAYS; w++)
        begin
            t = ft_rdata[w*FTAG_W +: FTAG_W];
            a = fv[w] ? ft_rdata[FAR_WAYS*FTAG_W + w*AGE_W +: AGE_W] : '0;
            if (FWAY_W'(w) == used)
            begin
                fnew_next[w*FTAG_W +: FTAG_W]                  = ftag;
                fnew_next[FAR_WAYS*FTAG_W + w*AGE_W +: AGE_W]  = '0;
            end
            else
            begin
                fnew_next[w*FTAG_W +: FTAG_W] = t;
                fnew_next[FAR_WAYS*FTAG_W + w*AGE_W +: AGE_W] =
                    (fv[w] && int'(a) < cltw_pkg::AGE_MAX) ? a + AGE_W'(1) : a;
            end
        end
    end

    // Sequencer: next state, memory controls and result.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        core_next     = core_reg;
        addr_next     = addr_reg;
        wdata_next    = wdata_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        res_word_next = res_word_reg;
        res_srv_next  = res_srv_reg;
        res_lat_next  = res_lat_reg;
        res_err_next  = res_err_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_word_next   = m_word_reg;
        m_srv_next    = m_srv_reg;
        m_lat_next    = m_lat_reg;
        m_err_next    = m_err_reg;
        m_we          = 1'b0;
        m_waddr       = MA_W'(addr_reg[ADDR_W-1:2]);
        m_wdata       = wdata_reg;
        nd_we         = 1'b0;
        nd_waddr      = nd_base + NDA_W'(off);
        nd_wdata      = wdata_reg;
        nd_raddr      = nd_base + NDA_W'(off);
        fd_we         = 1'b0;
        fd_waddr      = fd_base + FDA_W'(off);
        fd_wdata      = wdata_reg;
        nt_we         = 1'b0;
        ft_we         = 1'b0;
        nv_set        = 1'b0;
        fv_set        = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            cltw_pkg::ST_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = '0;
                clr_next = clr_reg + MA_W'(1);
                if (clr_reg == MA_W'(MEM_WORDS - 1))
                begin
                    state_next = cltw_pkg::ST_IDLE;
                end
            end
            cltw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next       = s_tdata[0];
                    core_next     = s_tdata[2:1];
                    addr_next     = in_addr;
                    wdata_next    = s_tdata[46:15];
                    res_word_next = '0;
                    res_srv_next  = cltw_pkg::SRV_L1;
                    res_lat_next  = '0;
                    res_err_next  = in_err;
                    state_next    = in_err ? cltw_pkg::ST_RESP : cltw_pkg::ST_TAGRD;
                end
            end
            cltw_pkg::ST_TAGRD:
            begin
                state_next = cltw_pkg::ST_TAGCHK;
            end
            cltw_pkg::ST_TAGCHK:
            begin
                state_next = cltw_pkg::ST_ACT;
            end
            cltw_pkg::ST_ACT:
            begin
                cnt_next = 2'd0;
                if (op_reg == cltw_pkg::OP_WRITE)
                begin
                    // Write through to memory; update only lines already present.
                    m_we  = 1'b1;
                    nd_we = nhit_reg;
                    nt_we = nhit_reg;
                    fd_we = fhit_reg;
                    ft_we = fhit_reg;
                    res_srv_next = nhit_reg ? cltw_pkg::SRV_L1 : cltw_pkg::SRV_MEM;
                    res_lat_next = nhit_reg ? lat1_reg : lat3_reg;
                    state_next   = cltw_pkg::ST_RESP;
                end
                else if (nhit_reg)
                begin
                    nt_we        = 1'b1;
                    res_srv_next = cltw_pkg::SRV_L1;
                    res_lat_next = lat1_reg;
                    state_next   = cltw_pkg::ST_WAITRD;
                end
                else
                begin
                    state_next = cltw_pkg::ST_COPY;
                end
            end
            cltw_pkg::ST_WAITRD:
            begin
                res_word_next = nd_rdata;
                state_next    = cltw_pkg::ST_RESP;
            end
            cltw_pkg::ST_COPY:
            begin
                // Fill one line word per cycle into the first level, and on a
                // miss into the second level as well.
                nd_we    = 1'b1;
                nd_waddr = nd_base + NDA_W'(cnt_reg);
                nd_wdata = src_word;
                fd_we    = !fhit_reg;
                fd_waddr = fd_base + FDA_W'(cnt_reg);
                fd_wdata = src_word;
                if (cnt_reg == off)
                begin
                    res_word_next = src_word;
                end
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    nt_we        = 1'b1;
                    ft_we        = 1'b1;
                    nv_set       = 1'b1;
                    fv_set       = !fhit_reg;
                    res_srv_next = fhit_reg ? cltw_pkg::SRV_L2 : cltw_pkg::SRV_MEM;
                    res_lat_next = fhit_reg ? lat2_reg : lat3_reg;
                    state_next   = cltw_pkg::ST_RESP;
                end
            end
            cltw_pkg::ST_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_word_reg;
                    m_srv_next   = res_srv_reg;
                    m_lat_next   = res_lat_reg;
                    m_err_next   = res_err_reg;
                    state_next   = cltw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cltw_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cltw_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers of the access, the lookup and the result.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        core_reg     <= core_next;
        addr_reg     <= addr_next;
        wdata_reg    <= wdata_next;
        cnt_reg      <= cnt_next;
        res_word_reg <= res_word_next;
        res_srv_reg  <= res_srv_next;
        res_lat_reg  <= res_lat_next;
        res_err_reg  <= res_err_next;
        m_word_reg   <= m_word_next;
        m_srv_reg    <= m_srv_next;
        m_lat_reg    <= m_lat_next;
        m_err_reg    <= m_err_next;
        if (state_reg == cltw_pkg::ST_TAGCHK)
        begin
            nhit_reg <= nhit_next;
            fhit_reg <= fhit_next;
            nway_reg <= nway_next;
            fway_reg <= fway_next;
            nnew_reg <= nnew_next;
            fnew_reg <= fnew_next;
        end
    end

    // Line valid bits; a filled way becomes valid at the end of its fill.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NROWS; r++)
            begin
                nvalid_reg[r] <= '0;
            end
            for (int r = 0; r < FAR_SETS; r++)
            begin
                fvalid_reg[r] <= '0;
            end
        end
        else
        begin
            if (nv_set)
            begin
                nvalid_reg[nrow][nway_reg] <= 1'b1;
            end
            if (fv_set)
            begin
                fvalid_reg[fset][fway_reg] <= 1'b1;
            end
        end
    end

    // Latency registers written over the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat1_reg <= cltw_pkg::RST_L1_LAT;
            lat2_reg <= cltw_pkg::RST_L2_LAT;
            lat3_reg <= cltw_pkg::RST_MEM_LAT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cltw_pkg::REG_L1_LAT:  lat1_reg <= cfg_data;
                cltw_pkg::REG_L2_LAT:  lat2_reg <= cfg_data;
                cltw_pkg::REG_MEM_LAT: lat3_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, m_err_reg, m_lat_reg, m_srv_reg, m_word_reg};

    // Checks on sequencing and result encoding.
    `CLTW_ASSERT(a_accept_next, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg == cltw_pkg::ST_TAGRD || state_reg == cltw_pkg::ST_RESP), "accepted access did not start a lookup")
    `CLTW_ASSERT(a_copy_end, clk, rst_n, (state_reg == cltw_pkg::ST_COPY && cnt_reg == 2'd3) |=> (state_reg == cltw_pkg::ST_RESP), "line fill did not end after four words")
    `CLTW_ASSERT(a_err_result, clk, rst_n, (m_tvalid && m_tdata[44]) |-> (m_tdata[43:0] == 44'd0), "error result carries data")
    `CLTW_ASSERT_NR(a_reset_out, clk, !rst_n |=> !m_tvalid, "result offered during reset")

endmodule

// ===== src/cltw_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module cltw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = cltw_pkg::clog2_min1(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
